FILE: hdl/rcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_pkg: shared types and constants of the RC stick channel mapper
// Item and result payloads, per-lane calibration view, register indexes,
// channel limits and pipeline widths.
// ----------------------------------------------------------------------------
package rcm_pkg;

    // Number of stick lanes and toggles
    localparam int NUM_STICKS  = 4;
    localparam int NUM_TOGGLES = 4;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_RANGE_0   = 3'd0;
    localparam logic [2:0] REG_RANGE_1   = 3'd1;
    localparam logic [2:0] REG_RANGE_2   = 3'd2;
    localparam logic [2:0] REG_RANGE_3   = 3'd3;
    localparam logic [2:0] REG_DZ_FRAC   = 3'd4;
    localparam logic [2:0] REG_DZ_ENABLE = 3'd5;
    localparam logic [2:0] REG_INVERT    = 3'd6;

    // Register reset values
    localparam logic [31:0] RANGE_RESET   = 32'h5B7C_0B65;
    localparam logic [15:0] DZ_FRAC_RESET = 16'd3277;
    localparam logic [3:0]  DZ_EN_RESET   = 4'd7;
    localparam logic [3:0]  INVERT_RESET  = 4'd9;

    // Channel values
    localparam logic [10:0] CH_MIN = 11'd1000;
    localparam logic [10:0] CH_MID = 11'd1500;
    localparam logic [10:0] CH_MAX = 11'd2000;

    // Map span and the narrow calibration margin
    localparam logic [9:0]  MAP_SPAN      = 10'd1000;
    localparam logic [16:0] NARROW_MARGIN = 17'd10;

    // Divider numerator widths and lane latency in cycles
    localparam int DZ_NUM_W  = 34;
    localparam int MAP_NUM_W = 27;
    localparam int DEN_W     = 16;
    localparam int LANE_LAT  = 5 + DZ_NUM_W + MAP_NUM_W;

    // Input item
    typedef struct packed {
        logic signed [15:0] stick_sample_0;
        logic signed [15:0] stick_sample_1;
        logic signed [15:0] stick_sample_2;
        logic signed [15:0] stick_sample_3;
        logic        [7:0]  toggle_pins;
    } t_item;

    // Result item
    typedef struct packed {
        logic [10:0] channel_0;
        logic [10:0] channel_1;
        logic [10:0] channel_2;
        logic [10:0] channel_3;
        logic [10:0] channel_4;
        logic [10:0] channel_5;
        logic [10:0] channel_6;
        logic [10:0] channel_7;
    } t_result;

    // Calibration seen by one stick lane
    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] frac;
        logic        dz_en;
        logic        inv;
    } t_lane_cfg;

endpackage

FILE: hdl/rcm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_div: pipelined unsigned restoring divider
// One quotient bit per stage, NUM_W stages; side data rides along so the
// caller gets its context back with the quotient.
// ----------------------------------------------------------------------------
module rcm_div #(
    parameter int NUM_W  = 34,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot,
    output logic [SIDE_W-1:0] o_side
);

    // Stage boundaries: index 0 is the input, index NUM_W the result
    logic              a_valid [0:NUM_W];
    logic [DEN_W-1:0]  a_rem   [0:NUM_W];
    logic [NUM_W-1:0]  a_nq    [0:NUM_W];
    logic [DEN_W-1:0]  a_den   [0:NUM_W];
    logic [SIDE_W-1:0] a_side  [0:NUM_W];

    assign a_valid[0] = i_valid;
    assign a_rem[0]   = '0;
    assign a_nq[0]    = i_num;
    assign a_den[0]   = i_den;
    assign a_side[0]  = i_side;

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W:0]    trial;
        logic              ge;
        logic [DEN_W-1:0]  n_rem;
        logic              r_valid;
        logic [DEN_W-1:0]  r_rem;
        logic [NUM_W-1:0]  r_nq;
        logic [DEN_W-1:0]  r_den;
        logic [SIDE_W-1:0] r_side;

        // Shift in the next numerator bit and try a subtract
        always_comb begin
            trial = {a_rem[k], a_nq[k][NUM_W-1]};
            ge    = (trial >= {1'b0, a_den[k]});
            if (ge) begin
                n_rem = DEN_W'(trial - {1'b0, a_den[k]});
            end else begin
                n_rem = trial[DEN_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else begin
                r_valid <= a_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem  <= n_rem;
            r_nq   <= {a_nq[k][NUM_W-2:0], ge};
            r_den  <= a_den[k];
            r_side <= a_side[k];
        end

        assign a_valid[k+1] = r_valid;
        assign a_rem[k+1]   = r_rem;
        assign a_nq[k+1]    = r_nq;
        assign a_den[k+1]   = r_den;
        assign a_side[k+1]  = r_side;
    end

    assign o_valid = a_valid[NUM_W];
    assign o_quot  = a_nq[NUM_W];
    assign o_side  = a_side[NUM_W];

endmodule

FILE: hdl/rcm_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcm_lane: one stick lane
// Deadzone around the calibration midpoint, linear map of min..max onto
// 1000..2000 (or reversed) and clamp; two pipelined dividers in line.
// ----------------------------------------------------------------------------
module rcm_lane
    import rcm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [15:0] i_sample,
    input  t_lane_cfg          i_cfg,
    output logic               o_valid,
    output logic [10:0]        o_channel
);

    typedef struct packed {
        logic [15:0] smp;
        logic [16:0] sum;
        logic        dpos;
        logic        in_dz;
        logic        narrow;
    } t_dz_side;

    typedef struct packed {
        logic xneg;
        logic narrow;
    } t_map_side;

    // ---- stage 1: center, range, offset and deadzone width ----
    logic [16:0]        c_sum;
    logic [15:0]        c_range;
    logic signed [18:0] c_d;
    logic [17:0]        c_mag;
    logic [31:0]        c_dzprod;
    logic               c_narrow;

    always_comb begin
        c_sum    = {1'b0, i_cfg.lo} + {1'b0, i_cfg.hi};
        c_range  = i_cfg.hi - i_cfg.lo;
        c_narrow = ({1'b0, i_cfg.hi} <= ({1'b0, i_cfg.lo} + NARROW_MARGIN));
        c_d      = $signed({{2{i_sample[15]}}, i_sample, 1'b0}) - $signed({2'b00, c_sum});
        c_mag    = c_d[18] ? 18'(-c_d) : c_d[17:0];
        c_dzprod = c_range * i_cfg.frac;
    end

    logic        r1_valid;
    logic [15:0] r1_smp;
    logic [16:0] r1_sum;
    logic [15:0] r1_range;
    logic [17:0] r1_mag;
    logic        r1_dpos;
    logic [15:0] r1_dz;
    logic        r1_narrow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_smp    <= i_sample;
        r1_sum    <= c_sum;
        r1_range  <= c_range;
        r1_mag    <= c_mag;
        r1_dpos   <= !c_d[18] && (c_d != '0);
        r1_dz     <= c_dzprod[31:16];
        r1_narrow <= c_narrow;
    end

    // ---- stage 2: stretch numerator and denominator ----
    logic [17:0] c_over;
    logic        c_in_dz;

    always_comb begin
        c_in_dz = (r1_mag < {2'b00, r1_dz});
        c_over  = r1_mag - {2'b00, r1_dz};
    end

    logic              r2_valid;
    logic [DZ_NUM_W-1:0] r2_num;
    logic [DEN_W-1:0]  r2_den;
    t_dz_side          r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_num         <= {16'd0, c_over} * {18'd0, r1_range};
        r2_den         <= r1_range - r1_dz;
        r2_side.smp    <= r1_smp;
        r2_side.sum    <= r1_sum;
        r2_side.dpos   <= r1_dpos;
        r2_side.in_dz  <= c_in_dz;
        r2_side.narrow <= r1_narrow;
    end

    // ---- deadzone stretch divider ----
    logic                d1_valid;
    logic [DZ_NUM_W-1:0] d1_quot;
    t_dz_side            d1_side;

    rcm_div #(
        .NUM_W  (DZ_NUM_W),
        .DEN_W  (DEN_W),
        .SIDE_W ($bits(t_dz_side))
    ) u_dz_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_valid),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .i_side  (r2_side),
        .o_valid (d1_valid),
        .o_quot  (d1_quot),
        .o_side  (d1_side)
    );

    // ---- stage 3: rebuild the deadzoned sample and saturate ----
    logic signed [35:0] c_t;
    logic signed [35:0] c_half;
    logic signed [16:0] c_sat;
    logic signed [16:0] c_v;

    always_comb begin
        if (d1_side.dpos) begin
            c_t = $signed({19'd0, d1_side.sum}) + $signed({2'b00, d1_quot});
        end else begin
            c_t = $signed({19'd0, d1_side.sum}) - $signed({2'b00, d1_quot});
        end
        c_half = (c_t + $signed({35'd0, c_t[35]})) >>> 1;
        if (c_half > 36'sd32767) begin
            c_sat = 17'sd32767;
        end else if (c_half < -36'sd32768) begin
            c_sat = -17'sd32768;
        end else begin
            c_sat = c_half[16:0];
        end
        if (!i_cfg.dz_en) begin
            c_v = {d1_side.smp[15], d1_side.smp};
        end else if (d1_side.in_dz) begin
            c_v = {1'b0, d1_side.sum[16:1]};
        end else begin
            c_v = c_sat;
        end
    end

    logic               r3_valid;
    logic signed [16:0] r3_v;
    logic               r3_narrow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_v      <= c_v;
        r3_narrow <= d1_side.narrow;
    end

    // ---- stage 4: offset from min, scale by the map span ----
    logic signed [17:0] c_x;
    logic [16:0]        c_xmag;

    always_comb begin
        c_x    = $signed({r3_v[16], r3_v}) - $signed({2'b00, i_cfg.lo});
        c_xmag = c_x[17] ? 17'(-c_x) : c_x[16:0];
    end

    logic                 r4_valid;
    logic [MAP_NUM_W-1:0] r4_num;
    logic [DEN_W-1:0]     r4_den;
    t_map_side            r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_num         <= {10'd0, c_xmag} * {17'd0, MAP_SPAN};
        r4_den         <= i_cfg.hi - i_cfg.lo;
        r4_side.xneg   <= c_x[17];
        r4_side.narrow <= r3_narrow;
    end

    // ---- map divider ----
    logic                 d2_valid;
    logic [MAP_NUM_W-1:0] d2_quot;
    t_map_side            d2_side;

    rcm_div #(
        .NUM_W  (MAP_NUM_W),
        .DEN_W  (DEN_W),
        .SIDE_W ($bits(t_map_side))
    ) u_map_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_valid),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .i_side  (r4_side),
        .o_valid (d2_valid),
        .o_quot  (d2_quot),
        .o_side  (d2_side)
    );

    // ---- stage 5: offset, direction and clamp ----
    logic [10:0] c_step;
    logic [10:0] n_channel;

    always_comb begin
        if (d2_quot >= MAP_NUM_W'(MAP_SPAN)) begin
            c_step = {1'b0, MAP_SPAN};
        end else begin
            c_step = {1'b0, d2_quot[9:0]};
        end
        if (d2_side.narrow) begin
            n_channel = CH_MID;
        end else if (i_cfg.inv) begin
            n_channel = d2_side.xneg ? CH_MAX : (CH_MAX - c_step);
        end else begin
            n_channel = d2_side.xneg ? CH_MIN : (CH_MIN + c_step);
        end
    end

    logic        r5_valid;
    logic [10:0] r5_channel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_channel <= n_channel;
    end

    assign o_valid   = r5_valid;
    assign o_channel = r5_channel;

endmodule

FILE: hdl/rc_stick_channel_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_stick_channel_mapper: four stick lanes and four toggles to RC channels
// Calibration registers, four parallel stick lanes, toggle decode and the
// merging output register.
// ----------------------------------------------------------------------------
// The block takes one item per clock: o_busy is low whenever reset is not
// asserted. Each item comes out as one result on o_result, marked by
// o_done for a single cycle, after it has passed the stage registers and
// the two bit-per-stage divider pipelines of every stick lane and the
// merging output register. Results cannot be held off, so the receiver must
// take o_result in the cycle o_done is high. Write calibration only while no
// item is in flight.
module rc_stick_channel_mapper
    import rcm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_item       i_item,
    output logic        o_done,
    output t_result     o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // Accept an item every cycle outside reset
    logic c_accept;

    assign o_busy   = !i_rst_n;
    assign c_accept = i_start && !o_busy;

    // ---- configuration registers ----
    logic [31:0] r_range [0:NUM_STICKS-1];
    logic [15:0] r_dz_frac;
    logic [3:0]  r_dz_en;
    logic [3:0]  r_invert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STICKS; i++) begin
                r_range[i] <= RANGE_RESET;
            end
            r_dz_frac <= DZ_FRAC_RESET;
            r_dz_en   <= DZ_EN_RESET;
            r_invert  <= INVERT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RANGE_0:   r_range[0] <= i_cfg_data;
                REG_RANGE_1:   r_range[1] <= i_cfg_data;
                REG_RANGE_2:   r_range[2] <= i_cfg_data;
                REG_RANGE_3:   r_range[3] <= i_cfg_data;
                REG_DZ_FRAC:   r_dz_frac  <= i_cfg_data[15:0];
                REG_DZ_ENABLE: r_dz_en    <= i_cfg_data[3:0];
                REG_INVERT:    r_invert   <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // ---- stick lanes ----
    logic signed [15:0] c_sample [0:NUM_STICKS-1];
    logic [NUM_STICKS-1:0] c_lane_valid;
    logic [10:0]        c_lane_ch [0:NUM_STICKS-1];

    assign c_sample[0] = i_item.stick_sample_0;
    assign c_sample[1] = i_item.stick_sample_1;
    assign c_sample[2] = i_item.stick_sample_2;
    assign c_sample[3] = i_item.stick_sample_3;

    for (genvar g = 0; g < NUM_STICKS; g++) begin : g_lane
        t_lane_cfg c_cfg;

        always_comb begin
            c_cfg.lo    = r_range[g][15:0];
            c_cfg.hi    = r_range[g][31:16];
            c_cfg.frac  = r_dz_frac;
            c_cfg.dz_en = r_dz_en[g];
            c_cfg.inv   = r_invert[g];
        end

        rcm_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (c_accept),
            .i_sample  (c_sample[g]),
            .i_cfg     (c_cfg),
            .o_valid   (c_lane_valid[g]),
            .o_channel (c_lane_ch[g])
        );
    end

    // ---- toggle pins: delay alongside the lanes ----
    logic [7:0] r_tog [0:LANE_LAT-1];

    always_ff @(posedge i_clk) begin
        r_tog[0] <= i_item.toggle_pins;
        for (int i = 1; i < LANE_LAT; i++) begin
            r_tog[i] <= r_tog[i-1];
        end
    end

    // Decode each pin pair
    logic [10:0] c_tog_ch [0:NUM_TOGGLES-1];

    always_comb begin
        for (int i = 0; i < NUM_TOGGLES; i++) begin
            case (r_tog[LANE_LAT-1][2*i +: 2])
                2'b01:   c_tog_ch[i] = CH_MIN;
                2'b10:   c_tog_ch[i] = CH_MAX;
                default: c_tog_ch[i] = CH_MID;
            endcase
        end
    end

    // ---- merge into the result register ----
    logic    r_done;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= &c_lane_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.channel_0 <= c_lane_ch[0];
        r_result.channel_1 <= c_lane_ch[1];
        r_result.channel_2 <= c_lane_ch[2];
        r_result.channel_3 <= c_lane_ch[3];
        r_result.channel_4 <= c_tog_ch[0];
        r_result.channel_5 <= c_tog_ch[1];
        r_result.channel_6 <= c_tog_ch[2];
        r_result.channel_7 <= c_tog_ch[3];
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: tb/sv/rc_stick_channel_mapper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_stick_channel_mapper_tb: self-checking bench of the RC channel mapper
// Drives stick samples and toggle pins through the command handshake and
// writes calibration between phases. A scoreboard computes the channel values
// of every accepted item and compares them field by field with the strobed
// results, in order.
// ----------------------------------------------------------------------------
module rc_stick_channel_mapper_tb;
    import rcm_pkg::*;

    localparam int  SETTLE_CYCLES = LANE_LAT + 20;
    localparam int  STALL_LIMIT   = 4000;
    localparam int  NUM_PHASES    = 8;
    localparam int  PHASE_ITEMS   = 200;

    // Expected channel values and the calibration they are computed from
    class channel_scoreboard;
        logic [31:0]  range_q [NUM_STICKS];
        logic [15:0]  dz_frac;
        logic [3:0]   dz_en_mask;
        logic [3:0]   inv_mask;
        t_result      pending_q [$];
        int           mismatches;

        function new();
            for (int k = 0; k < NUM_STICKS; k++) range_q[k] = RANGE_RESET;
            dz_frac    = DZ_FRAC_RESET;
            dz_en_mask = DZ_EN_RESET;
            inv_mask   = INVERT_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_RANGE_0, REG_RANGE_1, REG_RANGE_2, REG_RANGE_3:
                    range_q[idx[1:0]] = data;
                REG_DZ_FRAC:   dz_frac    = data[15:0];
                REG_DZ_ENABLE: dz_en_mask = data[3:0];
                REG_INVERT:    inv_mask   = data[3:0];
                default: ;
            endcase
        endfunction

        // Squeeze the deadzone out around the midpoint, in half units
        function longint apply_deadzone(longint v, longint lo, longint hi);
            longint s, r, dz, d, mag, adj, t, res;
            s   = lo + hi;
            r   = hi - lo;
            dz  = (r * longint'(dz_frac)) / 65536;
            d   = 2 * v - s;
            mag = (d < 0) ? -d : d;
            if (mag < dz) return s / 2;
            adj = ((mag - dz) * r) / (r - dz);
            t   = (d > 0) ? s + adj : s - adj;
            res = t / 2;
            if (res > 32767) res = 32767;
            if (res < -32768) res = -32768;
            return res;
        endfunction

        function logic [10:0] stick_channel(int lane, logic signed [15:0] sample);
            longint lo, hi, v, m;
            lo = longint'(range_q[lane][15:0]);
            hi = longint'(range_q[lane][31:16]);
            v  = longint'(sample);
            if (hi <= lo + 10) return CH_MID;
            if (dz_en_mask[lane]) v = apply_deadzone(v, lo, hi);
            if (inv_mask[lane]) m = (v - lo) * (-1000) / (hi - lo) + 2000;
            else                m = (v - lo) * 1000 / (hi - lo) + 1000;
            if (m < 1000) m = 1000;
            if (m > 2000) m = 2000;
            return m[10:0];
        endfunction

        function logic [10:0] toggle_channel(logic [7:0] pins, int k);
            if (pins[2*k] && !pins[2*k+1]) return CH_MIN;
            if (!pins[2*k] && pins[2*k+1]) return CH_MAX;
            return CH_MID;
        endfunction

        function void note_item(t_item it);
            t_result r;
            r.channel_0 = stick_channel(0, it.stick_sample_0);
            r.channel_1 = stick_channel(1, it.stick_sample_1);
            r.channel_2 = stick_channel(2, it.stick_sample_2);
            r.channel_3 = stick_channel(3, it.stick_sample_3);
            r.channel_4 = toggle_channel(it.toggle_pins, 0);
            r.channel_5 = toggle_channel(it.toggle_pins, 1);
            r.channel_6 = toggle_channel(it.toggle_pins, 2);
            r.channel_7 = toggle_channel(it.toggle_pins, 3);
            pending_q.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result     want;
            logic [87:0] w, g;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending_q.pop_front();
            w = want;
            g = got;
            for (int k = 0; k < 8; k++) begin
                if (w[87-11*k -: 11] !== g[87-11*k -: 11]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("channel_%0d mismatch: expected %0d, got %0d",
                                 k, w[87-11*k -: 11], g[87-11*k -: 11]);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_item       i_item;
    logic        o_done;
    t_result     o_result;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    channel_scoreboard sb;
    int                stall_cycles;
    bit                idle_enable;

    rc_stick_channel_mapper uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watch both handshakes and the config port; track stalls
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.write_reg(i_cfg_idx, i_cfg_data);
            if (i_start && !o_busy) sb.note_item(i_item);
            if (o_done) sb.check_result(o_result);
            if ((i_start && !o_busy) || o_done || i_cfg_we) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Hold the item until taken; insert a random gap now and then
    task automatic send_item(t_item it);
        int gap;
        i_start <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain pending items, then let the pipeline settle
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [31:0] pick_range();
        logic [15:0] lo, hi;
        case ($urandom_range(0, 7))
            0: begin lo = 16'($urandom); hi = lo + 16'd10; end
            1: begin lo = 16'($urandom); hi = lo + 16'd11; end
            2: begin lo = 16'($urandom); hi = 16'($urandom); end
            3: begin lo = 16'd0; hi = 16'hFFFF; end
            default: begin
                lo = 16'($urandom_range(0, 30000));
                hi = lo + 16'($urandom_range(11, 35000 - lo));
            end
        endcase
        return {hi, lo};
    endfunction

    function automatic logic signed [15:0] pick_sample(int lane);
        int lo, hi;
        lo = sb.range_q[lane][15:0];
        hi = sb.range_q[lane][31:16];
        if (hi < lo) begin
            hi = lo;
            lo = sb.range_q[lane][31:16];
        end
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2, 3, 4: return 16'($urandom);
            default: return 16'($urandom_range(lo, hi + 400) - 200);
        endcase
    endfunction

    function automatic t_item random_item();
        t_item it;
        it.stick_sample_0 = pick_sample(0);
        it.stick_sample_1 = pick_sample(1);
        it.stick_sample_2 = pick_sample(2);
        it.stick_sample_3 = pick_sample(3);
        it.toggle_pins    = 8'($urandom);
        return it;
    endfunction

    initial begin
        logic [31:0]      ranges [NUM_STICKS];
        logic signed [15:0] probe [8];
        logic [7:0]       pins [6];
        t_item            it;

        sb           = new();
        stall_cycles = 0;
        idle_enable  = 1'b1;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_item       = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_RANGE_0;
        i_cfg_data   = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, calibration ends, midpoint, toggle codes
        probe = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF,
                  16'sd2917, 16'sd23420, 16'sd13168, 16'sd13300};
        pins  = '{8'h00, 8'h55, 8'hAA, 8'hFF, 8'h1B, 8'hE4};
        for (int k = 0; k < 8; k++) begin
            it.stick_sample_0 = probe[k];
            it.stick_sample_1 = probe[(k + 1) % 8];
            it.stick_sample_2 = probe[(k + 2) % 8];
            it.stick_sample_3 = probe[(k + 3) % 8];
            it.toggle_pins    = pins[k % 6];
            send_item(it);
        end

        // Narrow, reversed and full-scale ranges; deadzone extremes
        drain();
        write_reg(REG_RANGE_0, {16'd1010, 16'd1000});
        write_reg(REG_RANGE_1, {16'd1011, 16'd1000});
        write_reg(REG_RANGE_2, {16'd0, 16'hFFFF});
        write_reg(REG_RANGE_3, {16'hFFFF, 16'd0});
        write_reg(REG_DZ_FRAC, 32'hFFFF);
        write_reg(REG_DZ_ENABLE, 32'hF);
        write_reg(REG_INVERT, 32'h0);
        write_reg(3'd7, 32'hFFFF_FFFF);
        for (int k = 0; k < 8; k++) begin
            it.stick_sample_0 = probe[k];
            it.stick_sample_1 = probe[(k + 5) % 8];
            it.stick_sample_2 = probe[(k + 2) % 8];
            it.stick_sample_3 = probe[(k + 7) % 8];
            it.toggle_pins    = 8'($urandom);
            send_item(it);
        end
        drain();
        write_reg(REG_DZ_FRAC, 32'h0);
        write_reg(REG_INVERT, 32'hF);
        write_reg(REG_DZ_ENABLE, 32'h0);
        for (int k = 0; k < 8; k++) send_item(random_item());

        // Random phases, each under its own calibration
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            for (int k = 0; k < NUM_STICKS; k++) ranges[k] = pick_range();
            write_reg(REG_RANGE_0, ranges[0]);
            write_reg(REG_RANGE_1, ranges[1]);
            write_reg(REG_RANGE_2, ranges[2]);
            write_reg(REG_RANGE_3, ranges[3]);
            case (p % 4)
                0: write_reg(REG_DZ_FRAC, 32'h0);
                1: write_reg(REG_DZ_FRAC, 32'hFFFF);
                default: write_reg(REG_DZ_FRAC, $urandom_range(0, 16000));
            endcase
            write_reg(REG_DZ_ENABLE, $urandom);
            write_reg(REG_INVERT, $urandom);
            if (p == NUM_PHASES - 1) idle_enable = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
        end

        // Let the pipeline empty out
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
